### rtl/cma_pkg.sv
// Shared types, defaults and register codes of the centered moving average block.
`timescale 1ns / 1ps
package cma_pkg;

   localparam int HalfMaxDefault    = 31;
   localparam int SampleBitsDefault = 16;
   localparam int LengthBitsDefault = 16;

   localparam int SeqLenReset   = 1024;
   localparam int HalfWinBits   = 5;
   localparam int CsrIndexBits  = 2;

   localparam logic [CsrIndexBits-1:0] REG_SEQ_LEN  = 2'd0;
   localparam logic [CsrIndexBits-1:0] REG_HALF_WIN = 2'd1;
   localparam logic [CsrIndexBits-1:0] REG_COMPLEX  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_ACC,
      ST_DIV,
      ST_EMIT
   } cma_state_type;

   typedef struct packed {
      logic accept;
      logic setup;
      logic acc;
      logic div_start;
      logic emit;
   } cma_cmd_type;

   typedef struct packed {
      logic any_result;
      logic acc_done;
      logic div_done;
      logic more;
      logic out_free;
   } cma_status_type;

endpackage

### rtl/cma_ctrl.sv
// Controller state machine that sequences window setup, accumulation, division and output.
`timescale 1ns / 1ps
module cma_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  cma_pkg::cma_status_type status,
   output logic                    req_tready,
   output cma_pkg::cma_cmd_type    cmd
);
   import cma_pkg::*;

   cma_state_type state_ff;
   cma_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && status.any_result) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (status.acc_done) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) state_in = status.more ? ST_SETUP : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      cmd           = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = !reset;
            cmd.accept = req_tvalid && !reset;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
         end
         ST_ACC: begin
            cmd.div_start = status.acc_done;
            cmd.acc       = !status.acc_done;
         end
         ST_DIV: begin
            cmd = '0;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### rtl/cma_divider.sv
// Bit-serial restoring divider for a signed sum by a small unsigned count, truncating to zero.
`timescale 1ns / 1ps
module cma_divider #(
   parameter int SUM_W = 22,
   parameter int DIV_W = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic [SUM_W-1:0] quotient,
   output logic             done
);
   localparam int STEP_W = $clog2(SUM_W + 1);

   logic [STEP_W-1:0] steps_ff, steps_in;
   logic              neg_ff, neg_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W:0]    rem_sh;
   logic              ge;

   always_comb begin
      rem_sh   = {rem_ff, quo_ff[SUM_W-1]};
      ge       = rem_sh >= {1'b0, divisor};
      steps_in = steps_ff;
      neg_in   = neg_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      if (start) begin
         steps_in = STEP_W'(SUM_W);
         neg_in   = dividend[SUM_W-1];
         quo_in   = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
         rem_in   = '0;
      end else if (steps_ff != '0) begin
         steps_in = steps_ff - 1'b1;
         quo_in   = {quo_ff[SUM_W-2:0], ge};
         rem_in   = ge ? DIV_W'(rem_sh - {1'b0, divisor}) : DIV_W'(rem_sh);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
      end else begin
         steps_ff <= steps_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = (steps_ff == '0);
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

### rtl/cma_dpath.sv
// Datapath: configuration registers, sample ring, window accumulators, dividers and output stage.
`timescale 1ns / 1ps
module cma_dpath #(
   parameter int HALF_MAX    = cma_pkg::HalfMaxDefault,
   parameter int SAMPLE_BITS = cma_pkg::SampleBitsDefault,
   parameter int LENGTH_BITS = cma_pkg::LengthBitsDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [cma_pkg::CsrIndexBits-1:0]  csr_index,
   input  logic [LENGTH_BITS-1:0]            csr_wdata,
   input  logic [SAMPLE_BITS-1:0]            sample_re,
   input  logic [SAMPLE_BITS-1:0]            sample_im,
   input  cma_pkg::cma_cmd_type              cmd,
   output cma_pkg::cma_status_type           status,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [SAMPLE_BITS-1:0]            avg_re,
   output logic [SAMPLE_BITS-1:0]            avg_im,
   output logic [LENGTH_BITS-1:0]            position,
   output logic                              rsp_tlast
);
   import cma_pkg::*;

   localparam int RING_DEPTH = 2 * HALF_MAX + 2;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int SUM_W      = SAMPLE_BITS + RING_AW;
   localparam int PW         = LENGTH_BITS + 2;

   logic [LENGTH_BITS-1:0] seq_len_ff;
   logic [HalfWinBits-1:0] half_win_ff;
   logic                   complex_ff;

   logic [LENGTH_BITS-1:0] samples_in_ff, results_out_ff;
   logic [RING_AW-1:0]     wp_ff, cur_wp_ff;
   logic [LENGTH_BITS-1:0] cur_j_ff, k_ff, k1_ff;

   logic [RING_AW-1:0]     addr_ff, cnt_ff, left_ff;
   logic                   rdv_ff;
   logic [SAMPLE_BITS-1:0] rd_re_ff, rd_im_ff;
   logic [SUM_W-1:0]       acc_re_ff, acc_im_ff;

   logic [SAMPLE_BITS-1:0] ring_re [RING_DEPTH];
   logic [SAMPLE_BITS-1:0] ring_im [RING_DEPTH];

   logic [PW-1:0] n_len, nm1_half, h_cap, h_eff, j_w, k_w, lo, cnt_w, diff_w;
   logic          is_last, j_ge_h, in_left, in_right;
   logic [RING_AW-1:0] diff, start_addr, wp_next, addr_next;
   logic [RING_AW:0]   wrap_sum;
   logic [SUM_W-1:0]   q_re, q_im;
   logic               div_done_re, div_done_im;

   always_comb begin
      n_len    = (seq_len_ff == '0) ? PW'(1) : PW'(seq_len_ff);
      nm1_half = (n_len - PW'(1)) >> 1;
      h_cap    = (PW'(half_win_ff) < PW'(HALF_MAX)) ? PW'(half_win_ff) : PW'(HALF_MAX);
      h_eff    = (h_cap < nm1_half) ? h_cap : nm1_half;
      j_w      = PW'(samples_in_ff);
      is_last  = (j_w + PW'(1)) >= n_len;
      j_ge_h   = j_w >= h_eff;
      wp_next  = (wp_ff == RING_AW'(RING_DEPTH - 1)) ? '0 : wp_ff + 1'b1;

      k_w      = PW'(k_ff);
      in_left  = k_w < h_eff;
      in_right = (k_w + h_eff + PW'(1)) > n_len;
      if (in_left) begin
         lo    = '0;
         cnt_w = (k_w << 1) + PW'(1);
      end else if (in_right) begin
         lo    = (k_w << 1) + PW'(1) - n_len;
         cnt_w = (n_len << 1) - (k_w << 1) - PW'(1);
      end else begin
         lo    = k_w - h_eff;
         cnt_w = (h_eff << 1) + PW'(1);
      end
      diff_w   = PW'(cur_j_ff) - lo;
      diff     = diff_w[RING_AW-1:0];
      wrap_sum = {1'b0, cur_wp_ff} + (RING_AW + 1)'(RING_DEPTH) - {1'b0, diff};
      start_addr = (cur_wp_ff >= diff) ? (cur_wp_ff - diff) : wrap_sum[RING_AW-1:0];
      addr_next  = (addr_ff == RING_AW'(RING_DEPTH - 1)) ? '0 : addr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_len_ff     <= LENGTH_BITS'(SeqLenReset);
         half_win_ff    <= '0;
         complex_ff     <= 1'b1;
         samples_in_ff  <= '0;
         results_out_ff <= '0;
         wp_ff          <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_SEQ_LEN:  seq_len_ff  <= csr_wdata;
            REG_HALF_WIN: half_win_ff <= csr_wdata[HalfWinBits-1:0];
            REG_COMPLEX:  complex_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
         samples_in_ff  <= '0;
         results_out_ff <= '0;
         wp_ff          <= '0;
      end else if (cmd.accept) begin
         if (is_last) begin
            samples_in_ff  <= '0;
            results_out_ff <= '0;
            wp_ff          <= '0;
         end else begin
            samples_in_ff  <= samples_in_ff + 1'b1;
            wp_ff          <= wp_next;
            if (j_ge_h) results_out_ff <= results_out_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ring_re[wp_ff] <= sample_re;
         ring_im[wp_ff] <= complex_ff ? sample_im : '0;
      end
      rd_re_ff <= ring_re[addr_ff];
      rd_im_ff <= ring_im[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cur_j_ff  <= samples_in_ff;
         cur_wp_ff <= wp_ff;
         k_ff      <= is_last ? results_out_ff : LENGTH_BITS'(j_w - h_eff);
         k1_ff     <= is_last ? LENGTH_BITS'(n_len - PW'(1)) : LENGTH_BITS'(j_w - h_eff);
      end else if (cmd.emit) begin
         k_ff <= k_ff + 1'b1;
      end
      if (cmd.setup) begin
         addr_ff   <= start_addr;
         cnt_ff    <= cnt_w[RING_AW-1:0];
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (cmd.acc) begin
         if (left_ff != '0) addr_ff <= addr_next;
         if (rdv_ff) begin
            acc_re_ff <= acc_re_ff + {{RING_AW{rd_re_ff[SAMPLE_BITS-1]}}, rd_re_ff};
            acc_im_ff <= acc_im_ff + {{RING_AW{rd_im_ff[SAMPLE_BITS-1]}}, rd_im_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         rdv_ff  <= 1'b0;
      end else if (cmd.setup) begin
         left_ff <= cnt_w[RING_AW-1:0];
         rdv_ff  <= 1'b0;
      end else begin
         rdv_ff <= cmd.acc && (left_ff != '0);
         if (cmd.acc && (left_ff != '0)) left_ff <= left_ff - 1'b1;
      end
   end

   cma_divider #(
      .SUM_W(SUM_W),
      .DIV_W(RING_AW)
   ) u_div_re (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .dividend(acc_re_ff),
      .divisor (cnt_ff),
      .quotient(q_re),
      .done    (div_done_re)
   );

   cma_divider #(
      .SUM_W(SUM_W),
      .DIV_W(RING_AW)
   ) u_div_im (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .dividend(acc_im_ff),
      .divisor (cnt_ff),
      .quotient(q_im),
      .done    (div_done_im)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (cmd.emit) begin
         rsp_tvalid <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         avg_re    <= q_re[SAMPLE_BITS-1:0];
         avg_im    <= complex_ff ? q_im[SAMPLE_BITS-1:0] : '0;
         position  <= k_ff;
         rsp_tlast <= (k_ff == k1_ff);
      end
   end

   always_comb begin
      status.any_result = is_last || j_ge_h;
      status.acc_done   = (left_ff == '0) && !rdv_ff;
      status.div_done   = div_done_re && div_done_im;
      status.more       = (k_ff != k1_ff);
      status.out_free   = !rsp_tvalid || rsp_tready;
   end

endmodule

### rtl/centered_moving_average.sv
// Top level of the centered moving average block with shrinking windows at the block ends.
`timescale 1ns / 1ps
// Samples of a block of sequence_length values arrive one per request; for each position k
// the block returns the mean of a centred window of half-width h, shrinking symmetrically
// near either end, truncated toward zero. The effective h is the least of half_window,
// HALF_MAX and (N-1)/2. Result k leaves with sample k+h, and the last sample of a block
// flushes the remaining h+1 results. A request that causes no result leaves the block ready. For
// each result the ring memory is read one entry a cycle into the running sums over the window
// of cnt <= 2h+1 entries, then a bit-serial divider produces the mean. A new request is
// taken once the last result of the previous one sits in the output register. Any
// configuration write restarts the block. The ring memory needs no clearing after reset.
module centered_moving_average #(
   parameter int HALF_MAX    = cma_pkg::HalfMaxDefault,
   parameter int SAMPLE_BITS = cma_pkg::SampleBitsDefault,
   parameter int LENGTH_BITS = cma_pkg::LengthBitsDefault
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        csr_we,
   input  logic [cma_pkg::CsrIndexBits-1:0]            csr_index,
   input  logic [LENGTH_BITS-1:0]                      csr_wdata,
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   // sample_re, sample_im
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]          req_tdata,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // avg_re, avg_im, position
   output logic [((2*SAMPLE_BITS+LENGTH_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic                                        rsp_tlast
);
   import cma_pkg::*;

   localparam int OUT_W = ((2 * SAMPLE_BITS + LENGTH_BITS + 7) / 8) * 8;

   cma_cmd_type            cmd;
   cma_status_type         status;
   logic [SAMPLE_BITS-1:0] avg_re, avg_im;
   logic [LENGTH_BITS-1:0] position;

   cma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .status    (status),
      .req_tready(req_tready),
      .cmd       (cmd)
   );

   cma_dpath #(
      .HALF_MAX   (HALF_MAX),
      .SAMPLE_BITS(SAMPLE_BITS),
      .LENGTH_BITS(LENGTH_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .sample_re (req_tdata[SAMPLE_BITS-1:0]),
      .sample_im (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .cmd       (cmd),
      .status    (status),
      .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid),
      .avg_re    (avg_re),
      .avg_im    (avg_im),
      .position  (position),
      .rsp_tlast (rsp_tlast)
   );

   assign rsp_tdata = OUT_W'({position, avg_im, avg_re});

   a_no_result_ready: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !status.any_result) |=> req_tready)
      else $error("ready not restored after a request without results");

   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !status.div_done)
      else $error("divider did not start");

   a_hold_between_results: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.more) |=> !req_tready)
      else $error("request taken while results of the previous one remain");

endmodule
